// File: rtl/fmc_pkg.sv
// fmc_pkg: shared widths, event codes, register indexes, types and the duty
// table of the fan mode controller. No dependencies; used by every rtl file of the block.
package fmc_pkg;

  localparam int TIMER_WIDTH = 32;
  localparam int EXT_WIDTH   = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;
  localparam int TEMP_W      = 12;
  localparam int SPEED_W     = 3;
  localparam int DUTY_W      = 8;
  localparam int KIND_W      = 4;
  localparam int N_LEVELS    = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int NIGHT_W     = 3;
  localparam int DELAY_W     = 32;

  localparam logic [KIND_W-1:0] KIND_TICK       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LOCK       = 4'd1;
  localparam logic [KIND_W-1:0] KIND_UNLOCK     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_FAN_ON     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_FAN_OFF    = 4'd4;
  localparam logic [KIND_W-1:0] KIND_UP         = 4'd5;
  localparam logic [KIND_W-1:0] KIND_DOWN       = 4'd6;
  localparam logic [KIND_W-1:0] KIND_AUTO_ON    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_AUTO_OFF   = 4'd8;
  localparam logic [KIND_W-1:0] KIND_NIGHT_ON   = 4'd9;
  localparam logic [KIND_W-1:0] KIND_NIGHT_OFF  = 4'd10;
  localparam logic [KIND_W-1:0] KIND_TIMER_ON   = 4'd11;
  localparam logic [KIND_W-1:0] KIND_TIMER_OFF  = 4'd12;
  localparam logic [KIND_W-1:0] KIND_SAMPLE     = 4'd13;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd6;

  localparam logic [SPEED_W-1:0] SPEED_MAX     = 3'd5;
  localparam logic [SPEED_W-1:0] SPEED_DEFAULT = 3'd3;

  typedef struct packed {
    logic [N_LEVELS-1:0][TEMP_W-1:0] level;
    logic [NIGHT_W-1:0]              night_speed;
    logic [DELAY_W-1:0]              off_delay;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TEMP_W-1:0] temperature;
    logic              sample_valid;
  } item_t;

  typedef struct packed {
    logic                   locked;
    logic                   fan_on;
    logic                   auto_on;
    logic                   night_on;
    logic [SPEED_W-1:0]     speed;
    logic [TEMP_W-1:0]      temp;
    logic [TIMER_WIDTH-1:0] tcount;
    logic                   tact;
    logic [DUTY_W-1:0]      duty;
  } state_t;

  function automatic logic [DUTY_W-1:0] duty_lut(input logic [SPEED_W-1:0] spd);
    logic [DUTY_W-1:0] d;
    case (spd)
      3'd0:    d = 8'd0;
      3'd1:    d = 8'd112;
      3'd2:    d = 8'd142;
      3'd3:    d = 8'd182;
      3'd4:    d = 8'd222;
      default: d = 8'd245;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/fmc_cfg.sv
// fmc_cfg: configuration register bank (thresholds, night speed, off delay).
// Depends on fmc_pkg.
module fmc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output fmc_pkg::cfg_t                    cfg
);

  fmc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level[0]    <= 12'sd250;
      cfg_r.level[1]    <= 12'sd270;
      cfg_r.level[2]    <= 12'sd290;
      cfg_r.level[3]    <= 12'sd310;
      cfg_r.level[4]    <= 12'sd330;
      cfg_r.night_speed <= 3'd1;
      cfg_r.off_delay   <= 32'd3600;
    end else if (cfg_we) begin
      case (cfg_index)
        fmc_pkg::REG_LEVEL_1: cfg_r.level[0] <= cfg_wdata[fmc_pkg::TEMP_W-1:0];
        fmc_pkg::REG_LEVEL_2: cfg_r.level[1] <= cfg_wdata[fmc_pkg::TEMP_W-1:0];
        fmc_pkg::REG_LEVEL_3: cfg_r.level[2] <= cfg_wdata[fmc_pkg::TEMP_W-1:0];
        fmc_pkg::REG_LEVEL_4: cfg_r.level[3] <= cfg_wdata[fmc_pkg::TEMP_W-1:0];
        fmc_pkg::REG_LEVEL_5: cfg_r.level[4] <= cfg_wdata[fmc_pkg::TEMP_W-1:0];
        fmc_pkg::REG_NIGHT:   cfg_r.night_speed <= cfg_wdata[fmc_pkg::NIGHT_W-1:0];
        fmc_pkg::REG_DELAY:   cfg_r.off_delay <= cfg_wdata[fmc_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/fmc_core.sv
// fmc_core: controller state registers and the per-beat next-state logic.
// Depends on fmc_pkg; configuration comes from fmc_cfg.
module fmc_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  fmc_pkg::item_t  item,
  input  fmc_pkg::cfg_t   cfg,
  output fmc_pkg::state_t state_nxt
);

  fmc_pkg::state_t state_r;

  function automatic fmc_pkg::state_t fan_off(input fmc_pkg::state_t s);
    fmc_pkg::state_t r;
    r = s;
    if (r.fan_on) begin
      r.fan_on = 1'b0;
      r.duty   = '0;
      if (r.auto_on) begin
        r.auto_on = 1'b0;
        r.speed   = fmc_pkg::SPEED_DEFAULT;
      end
      if (r.night_on) begin
        r.night_on = 1'b0;
        r.speed    = fmc_pkg::SPEED_DEFAULT;
      end
    end
    return r;
  endfunction

  logic [fmc_pkg::SPEED_W-1:0]     auto_spd;
  logic [fmc_pkg::SPEED_W-1:0]     night_spd;
  logic [fmc_pkg::SPEED_W-1:0]     duty_spd;
  logic [fmc_pkg::EXT_WIDTH-1:0]   delay_ext;
  logic [fmc_pkg::EXT_WIDTH-1:0]   delay_lim;
  logic [fmc_pkg::TIMER_WIDTH-1:0] delay_sat;
  logic                            unlocked_on;
  fmc_pkg::state_t                 s;

  // highest threshold passed wins
  always_comb begin
    auto_spd = '0;
    for (int i = 0; i < fmc_pkg::N_LEVELS; i++) begin
      if ($signed(state_r.temp) > $signed(cfg.level[i])) begin
        auto_spd = fmc_pkg::SPEED_W'(i + 1);
      end
    end
  end

  assign night_spd = (cfg.night_speed > fmc_pkg::SPEED_MAX) ? fmc_pkg::SPEED_MAX
                                                             : cfg.night_speed;
  assign delay_ext = fmc_pkg::EXT_WIDTH'(cfg.off_delay);
  assign delay_lim = fmc_pkg::EXT_WIDTH'({fmc_pkg::TIMER_WIDTH{1'b1}});
  assign delay_sat = (delay_ext > delay_lim) ? fmc_pkg::TIMER_WIDTH'(delay_lim)
                                             : fmc_pkg::TIMER_WIDTH'(delay_ext);
  assign unlocked_on = !state_r.locked && state_r.fan_on;

  always_comb begin
    s = state_r;
    duty_spd = '0;
    case (item.kind)
      fmc_pkg::KIND_TICK: begin
        if (s.tact) begin
          if (s.tcount <= fmc_pkg::TIMER_WIDTH'(1)) begin
            s.tact   = 1'b0;
            s.tcount = '0;
            s        = fan_off(s);
          end else begin
            s.tcount = s.tcount - fmc_pkg::TIMER_WIDTH'(1);
          end
        end
        if (s.fan_on && !s.locked) begin
          if (s.auto_on) s.speed = auto_spd;
          if (s.night_on) s.speed = night_spd;
          duty_spd = (s.speed > fmc_pkg::SPEED_MAX) ? fmc_pkg::SPEED_MAX : s.speed;
          s.duty   = fmc_pkg::duty_lut(duty_spd);
        end else begin
          s.duty = '0;
        end
      end
      fmc_pkg::KIND_LOCK: begin
        if (!s.locked) begin
          s.locked = 1'b1;
          s        = fan_off(s);
        end
      end
      fmc_pkg::KIND_UNLOCK: begin
        if (s.locked) begin
          s.locked = 1'b0;
          s        = fan_off(s);
        end
      end
      fmc_pkg::KIND_FAN_ON: begin
        if (!s.locked && !s.fan_on) begin
          s.fan_on = 1'b1;
          if (s.auto_on) begin
            s.auto_on = 1'b0;
            s.speed   = fmc_pkg::SPEED_DEFAULT;
          end
          if (s.night_on) begin
            s.night_on = 1'b0;
            s.speed    = fmc_pkg::SPEED_DEFAULT;
          end
        end
      end
      fmc_pkg::KIND_FAN_OFF: s = fan_off(s);
      fmc_pkg::KIND_UP: begin
        s.speed = (s.speed < fmc_pkg::SPEED_MAX) ? s.speed + 3'd1 : fmc_pkg::SPEED_MAX;
      end
      fmc_pkg::KIND_DOWN: begin
        s.speed = (s.speed > 3'd1) ? s.speed - 3'd1 : 3'd1;
      end
      fmc_pkg::KIND_AUTO_ON: begin
        if (unlocked_on && !s.auto_on) begin
          s.night_on = 1'b0;
          s.auto_on  = 1'b1;
        end
      end
      fmc_pkg::KIND_AUTO_OFF: begin
        if (s.auto_on) begin
          s.auto_on = 1'b0;
          s.speed   = fmc_pkg::SPEED_DEFAULT;
        end
      end
      fmc_pkg::KIND_NIGHT_ON: begin
        if (unlocked_on && !s.night_on) begin
          s.auto_on  = 1'b0;
          s.night_on = 1'b1;
        end
      end
      fmc_pkg::KIND_NIGHT_OFF: begin
        if (s.night_on) begin
          s.night_on = 1'b0;
          s.speed    = fmc_pkg::SPEED_DEFAULT;
        end
      end
      fmc_pkg::KIND_TIMER_ON: begin
        if (unlocked_on) begin
          s.tact   = 1'b1;
          s.tcount = delay_sat;
        end
      end
      fmc_pkg::KIND_TIMER_OFF: s.tact = 1'b0;
      fmc_pkg::KIND_SAMPLE: begin
        if (item.sample_valid) s.temp = item.temperature;
      end
      default: ;
    endcase
    state_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.locked   <= 1'b1;
      state_r.fan_on   <= 1'b0;
      state_r.auto_on  <= 1'b0;
      state_r.night_on <= 1'b0;
      state_r.speed    <= fmc_pkg::SPEED_DEFAULT;
      state_r.temp     <= '0;
      state_r.tcount   <= '0;
      state_r.tact     <= 1'b0;
      state_r.duty     <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/fan_mode_controller.sv
// fan_mode_controller: top level with input beat register and result register.
// Depends on fmc_pkg, fmc_cfg and fmc_core.
//
// Usage: each event beat on the in_ channel (kind and sample_valid in tuser,
// temperature in tdata) yields exactly one status beat on the out_ channel,
// in order. A beat is taken into an input register, runs through the state
// update and lands in the output register, which drives out_tvalid; the
// update of a beat waits while the output register still holds a status
// beat that the receiver has not taken.
// Throughput is one beat per clock while out_tready stays high: the state
// update is a single shallow pass from the state registers back into them,
// the timer decrement being the widest path.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while no beat
// is in flight; indexes outside the register list are ignored.
// Reset (rst_n low at a clock edge) empties both registers, locks the
// device, turns the fan and all modes off and restores the default settings.
// When the receiver holds out_tready low, the output register keeps its
// beat and one more beat can wait in the input register before in_tready
// drops; nothing is lost or repeated.
module fan_mode_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // temperature[11:0], zero pad
  input  logic [4:0]                     in_tuser,  // kind[3:0], sample_valid[4]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // duty[7:0], speed_level[10:8],
                                                    // fan_running[11], auto_active[12],
                                                    // night_active[13], is_locked[14],
                                                    // timer_running[15]
  input  logic                           cfg_we,
  input  logic [fmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic            s1_valid_r;
  fmc_pkg::item_t  s1_item_r;
  logic            out_valid_r;
  logic [15:0]     out_data_r;
  logic            advance;
  fmc_pkg::cfg_t   cfg;
  fmc_pkg::state_t state_nxt;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.kind         <= in_tuser[3:0];
      s1_item_r.sample_valid <= in_tuser[4];
      s1_item_r.temperature  <= in_tdata[fmc_pkg::TEMP_W-1:0];
    end
  end

  fmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fmc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (s1_item_r),
    .cfg       (cfg),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {state_nxt.tact, state_nxt.locked, state_nxt.night_on,
                     state_nxt.auto_on, state_nxt.fan_on, state_nxt.speed,
                     state_nxt.duty};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
